// File: src/assert_macros.svh
// Assertion helpers; expect signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define CHECK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Trigger in one cycle implies the consequence in the next.
`define CHECK_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// File: src/rtcm_pkg.sv
package rtcm_pkg;

  localparam logic [7:0]  SYNC_BYTE = 8'hD3;
  localparam logic [23:0] CRC_POLY  = 24'h864CFB;
  localparam int          IW        = 11;
  localparam logic [IW-1:0] FRAME_OVERHEAD = 11'd6;
  localparam logic [IW-1:0] HDR_LEN        = 11'd3;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_TALLY = 2'd1;
  localparam logic [1:0] KIND_SNAP  = 2'd2;

  typedef enum logic [1:0] {
    RD_OFF0 = 2'd0,
    RD_OFF1 = 2'd1,
    RD_OFF2 = 2'd2,
    RD_NEXT = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    latch;
    logic    append;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    drop;
    logic    len_hi;
    logic    len_lo;
    logic    idx_clr;
    logic    idx_inc;
    logic    crc_clr;
    logic    crc_step;
    logic    good;
    logic    bad;
    logic    ti_clr;
    logic    ti_inc;
    logic    t_rd;
    logic    t_bump;
    logic    t_add;
    logic    snap_wr;
    logic    commit;
    logic    query;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic is_sync;
    logic cnt_lt3;
    logic cnt_lt_flen;
    logic crc_last;
    logic crc_ok;
    logic ti_end;
    logic type_match;
    logic copy_last;
    logic out_free;
  } stat_t;

  function automatic logic [23:0] crc24q_byte(input logic [23:0] acc_in,
                                              input logic [7:0] data);
    logic [23:0] acc;
    logic        top;
    acc = acc_in ^ {data, 16'h0000};
    for (int b = 0; b < 8; b++) begin
      top = acc[23];
      acc = {acc[22:0], 1'b0};
      if (top) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

endpackage

// File: src/rtcm_ctrl.sv
module rtcm_ctrl
  import rtcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] kind,
  input  stat_t      stat,
  output logic       in_ready,
  output cmd_t       cmd
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_APPEND = 16'h0002,
    S_SCAN   = 16'h0004,
    S_CHK    = 16'h0008,
    S_L1     = 16'h0010,
    S_L2     = 16'h0020,
    S_LEN    = 16'h0040,
    S_CRC    = 16'h0080,
    S_CMP    = 16'h0100,
    S_TRD    = 16'h0200,
    S_TCMP   = 16'h0400,
    S_TADD   = 16'h0800,
    S_CST    = 16'h1000,
    S_CWR    = 16'h2000,
    S_QRY    = 16'h4000,
    S_FIN    = 16'h8000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_OFF0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (kind)
            KIND_BYTE:  state_next = S_APPEND;
            KIND_TALLY: state_next = S_QRY;
            KIND_SNAP:  state_next = S_QRY;
            default:    state_next = S_FIN;
          endcase
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.cnt_zero) state_next = S_FIN;
        else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (!stat.is_sync) begin
          cmd.drop   = 1'b1;
          state_next = S_SCAN;
        end else if (stat.cnt_lt3) begin
          state_next = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_OFF1;
          state_next = S_L1;
        end
      end
      S_L1: begin
        cmd.len_hi = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_OFF2;
        state_next = S_L2;
      end
      S_L2: begin
        cmd.len_lo = 1'b1;
        state_next = S_LEN;
      end
      S_LEN: begin
        if (stat.cnt_lt_flen) state_next = S_FIN;
        else begin
          cmd.idx_clr = 1'b1;
          cmd.crc_clr = 1'b1;
          cmd.rd_en   = 1'b1;
          state_next  = S_CRC;
        end
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        if (stat.crc_last) state_next = S_CMP;
        else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_NEXT;
          cmd.idx_inc = 1'b1;
        end
      end
      S_CMP: begin
        if (stat.crc_ok) begin
          cmd.good   = 1'b1;
          cmd.ti_clr = 1'b1;
          state_next = S_TRD;
        end else begin
          cmd.bad    = 1'b1;
          cmd.drop   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_TRD: begin
        if (stat.ti_end) state_next = S_TADD;
        else begin
          cmd.t_rd   = 1'b1;
          state_next = S_TCMP;
        end
      end
      S_TCMP: begin
        if (stat.type_match) begin
          cmd.t_bump = 1'b1;
          state_next = S_CST;
        end else begin
          cmd.ti_inc = 1'b1;
          state_next = S_TRD;
        end
      end
      S_TADD: begin
        cmd.t_add  = 1'b1;
        state_next = S_CST;
      end
      S_CST: begin
        cmd.idx_clr = 1'b1;
        cmd.rd_en   = 1'b1;
        state_next  = S_CWR;
      end
      S_CWR: begin
        cmd.snap_wr = 1'b1;
        if (stat.copy_last) begin
          cmd.commit = 1'b1;
          state_next = S_SCAN;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_NEXT;
          cmd.idx_inc = 1'b1;
        end
      end
      S_QRY: begin
        cmd.query  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: src/rtcm_dp.sv
module rtcm_dp
  import rtcm_pkg::*;
#(
  parameter int BUF_DEPTH  = 2048,
  parameter int MAX_TYPES  = 16,
  parameter int SNAP_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] byte_count,
  output logic [31:0] frame_count,
  output logic [31:0] crc_failures,
  output logic [4:0]  distinct_types,
  output logic [11:0] entry_type,
  output logic [31:0] entry_count,
  output logic [6:0]  snapshot_length,
  output logic [7:0]  snapshot_byte
);

  `include "assert_macros.svh"

  localparam int AW  = $clog2(BUF_DEPTH);
  localparam int CW  = $clog2(BUF_DEPTH + 1);
  localparam int TIW = $clog2(MAX_TYPES + 1);
  localparam int TAW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int SW  = $clog2(SNAP_BYTES);
  localparam int LW  = $clog2(SNAP_BYTES + 1);

  logic [AW-1:0]  head;
  logic [CW-1:0]  count;
  logic [9:0]     plen;
  logic [IW-1:0]  idx;
  logic [23:0]    crc;
  logic [23:0]    want;
  logic [11:0]    mtype;
  logic [TIW-1:0] ti;
  logic [TIW-1:0] types_used;
  logic [LW-1:0]  copy_len;
  logic [31:0]    byte_total, good_frames, bad_frames;
  logic [1:0]     in_kind;
  logic [7:0]     in_data;
  logic [5:0]     in_idx;
  logic           q_tok, q_sok;

  logic [7:0]  pend_mem [BUF_DEPTH];
  logic [7:0]  pend_rd;
  logic [11:0] tal_type_mem [MAX_TYPES];
  logic [31:0] tal_cnt_mem  [MAX_TYPES];
  logic [11:0] tal_type_rd;
  logic [31:0] tal_cnt_rd;
  logic [7:0]  snap_mem [SNAP_BYTES];
  logic [7:0]  snap_rd;

  logic [IW-1:0] flen, hdr_len, snap_len, rd_off;
  logic [AW:0]   rd_sum, tail_sum, adv_sum, adv;
  logic [AW-1:0] rd_addr, tail, adv_head;
  logic [CW-1:0] eff_cnt;
  logic          out_free;

  assign flen     = {1'b0, plen} + FRAME_OVERHEAD;
  assign hdr_len  = {1'b0, plen} + HDR_LEN;
  assign snap_len = (flen < IW'(SNAP_BYTES)) ? flen : IW'(SNAP_BYTES);

  always_comb begin
    case (cmd.rd_sel)
      RD_OFF0: rd_off = '0;
      RD_OFF1: rd_off = IW'(1);
      RD_OFF2: rd_off = IW'(2);
      RD_NEXT: rd_off = idx + IW'(1);
      default: rd_off = '0;
    endcase
  end

  assign rd_sum  = {1'b0, head} + (AW+1)'(rd_off);
  assign rd_addr = (rd_sum >= (AW+1)'(BUF_DEPTH)) ? AW'(rd_sum - (AW+1)'(BUF_DEPTH))
                                                  : AW'(rd_sum);
  assign eff_cnt  = (count == CW'(BUF_DEPTH)) ? '0 : count;
  assign tail_sum = {1'b0, head} + (AW+1)'(eff_cnt);
  assign tail     = (tail_sum >= (AW+1)'(BUF_DEPTH))
                    ? AW'(tail_sum - (AW+1)'(BUF_DEPTH)) : AW'(tail_sum);
  assign adv      = cmd.commit ? (AW+1)'(flen) : (AW+1)'(1);
  assign adv_sum  = {1'b0, head} + adv;
  assign adv_head = (adv_sum >= (AW+1)'(BUF_DEPTH))
                    ? AW'(adv_sum - (AW+1)'(BUF_DEPTH)) : AW'(adv_sum);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    stat.cnt_zero    = (count == '0);
    stat.is_sync     = (pend_rd == SYNC_BYTE);
    stat.cnt_lt3     = (count < CW'(3));
    stat.cnt_lt_flen = (count < CW'(flen));
    stat.crc_last    = (idx == flen - IW'(1));
    stat.crc_ok      = (crc == want);
    stat.ti_end      = (ti == types_used);
    stat.type_match  = (tal_type_rd == mtype);
    stat.copy_last   = (idx == snap_len - IW'(1));
    stat.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.append) pend_mem[tail] <= in_data;
    if (cmd.rd_en)  pend_rd <= pend_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.t_rd || cmd.query) begin
      tal_type_rd <= tal_type_mem[cmd.query ? TAW'(in_idx) : ti[TAW-1:0]];
      tal_cnt_rd  <= tal_cnt_mem[cmd.query ? TAW'(in_idx) : ti[TAW-1:0]];
    end
    if (cmd.t_bump) tal_cnt_mem[ti[TAW-1:0]] <= tal_cnt_rd + 32'd1;
    if (cmd.t_add && (types_used < TIW'(MAX_TYPES))) begin
      tal_type_mem[types_used[TAW-1:0]] <= mtype;
      tal_cnt_mem[types_used[TAW-1:0]]  <= 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap_wr) snap_mem[idx[SW-1:0]] <= pend_rd;
    if (cmd.query)   snap_rd <= snap_mem[SW'(in_idx)];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_kind <= kind;
      in_data <= data_byte;
      in_idx  <= read_index;
    end
    if (cmd.len_hi) plen[9:8] <= pend_rd[1:0];
    if (cmd.len_lo) plen[7:0] <= pend_rd;
    if (cmd.idx_clr)      idx <= '0;
    else if (cmd.idx_inc) idx <= idx + IW'(1);
    if (cmd.crc_clr) crc <= '0;
    if (cmd.crc_step) begin
      if (idx < hdr_len) crc <= crc24q_byte(crc, pend_rd);
      else               want <= {want[15:0], pend_rd};
      if (idx == IW'(3)) mtype[11:4] <= pend_rd;
      if (idx == IW'(4)) mtype[3:0]  <= pend_rd[7:4];
    end
    if (cmd.ti_clr)      ti <= '0;
    else if (cmd.ti_inc) ti <= ti + TIW'(1);
    if (cmd.query) begin
      q_tok <= (7'(in_idx) < 7'(types_used));
      q_sok <= (11'(in_idx) < 11'(copy_len));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      count       <= '0;
      byte_total  <= '0;
      good_frames <= '0;
      bad_frames  <= '0;
      types_used  <= '0;
      copy_len    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.append) begin
        count      <= eff_cnt + CW'(1);
        byte_total <= byte_total + 32'd1;
      end
      if (cmd.drop) begin
        head  <= adv_head;
        count <= count - CW'(1);
      end
      if (cmd.commit) begin
        head     <= adv_head;
        count    <= count - CW'(flen);
        copy_len <= LW'(snap_len);
      end
      if (cmd.good) good_frames <= good_frames + 32'd1;
      if (cmd.bad)  bad_frames  <= bad_frames + 32'd1;
      if (cmd.t_add && (types_used < TIW'(MAX_TYPES))) types_used <= types_used + TIW'(1);
      if (cmd.load_out)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      byte_count      <= byte_total;
      frame_count     <= good_frames;
      crc_failures    <= bad_frames;
      distinct_types  <= 5'(types_used);
      snapshot_length <= 7'(copy_len);
      entry_type      <= (in_kind == KIND_TALLY && q_tok) ? tal_type_rd : '0;
      entry_count     <= (in_kind == KIND_TALLY && q_tok) ? tal_cnt_rd : '0;
      snapshot_byte   <= (in_kind == KIND_SNAP && q_sok) ? snap_rd : '0;
    end
  end

  `CHECK_ALWAYS(a_count_bound, count <= CW'(BUF_DEPTH), "pending count beyond buffer depth")
  `CHECK_ALWAYS(a_types_bound, types_used <= TIW'(MAX_TYPES), "tally use beyond table size")
  `CHECK_NEXT(a_bad_count, cmd.bad, bad_frames == $past(bad_frames) + 32'd1,
    "crc failure not counted")

endmodule

// File: src/rtcm3_frame_monitor.sv
// RTCM3 stream monitor.
// Input channel (in_valid/in_ready): kind 0 appends data_byte to the stream,
// kind 1 reads tally entry read_index, kind 2 reads snapshot byte read_index.
// Output channel (out_valid/out_ready): one transaction per input transaction
// with the byte, frame and failure counters, tally use, snapshot length and
// the addressed query fields.
// Sequence: a query reads the tally and snapshot tables in S_QRY and loads
// the output register in S_FIN. A stream byte is appended and the buffer
// scanned for a frame; a completed frame adds the CRC pass and compare, the
// tally search and the copy of min(flen, SNAP_BYTES) bytes to the snapshot.
// After a CRC failure the scan walks the buffered bytes again, dropping one
// byte at a time plus a pass per inner candidate frame. The single buffer
// read port serialises these passes. Reset clears counters, tally use and
// snapshot length; no clearing pass. A new transaction is accepted while a
// result waits; the next result holds until out_ready takes the pending one.
module rtcm3_frame_monitor
  import rtcm_pkg::*;
#(
  parameter int BUF_DEPTH  = 2048,
  parameter int MAX_TYPES  = 16,
  parameter int SNAP_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] byte_count,
  output logic [31:0] frame_count,
  output logic [31:0] crc_failures,
  output logic [4:0]  distinct_types,
  output logic [11:0] entry_type,
  output logic [31:0] entry_count,
  output logic [6:0]  snapshot_length,
  output logic [7:0]  snapshot_byte
);

  cmd_t  cmd;
  stat_t stat;

  rtcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  rtcm_dp #(
    .BUF_DEPTH  (BUF_DEPTH),
    .MAX_TYPES  (MAX_TYPES),
    .SNAP_BYTES (SNAP_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .kind            (kind),
    .data_byte       (data_byte),
    .read_index      (read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .byte_count      (byte_count),
    .frame_count     (frame_count),
    .crc_failures    (crc_failures),
    .distinct_types  (distinct_types),
    .entry_type      (entry_type),
    .entry_count     (entry_count),
    .snapshot_length (snapshot_length),
    .snapshot_byte   (snapshot_byte)
  );

endmodule
